### sv/mts_pkg.sv
// Package for the max-tracking stack: shared types, codes and defaults.
// Used by mts_ctrl, mts_dp and max_tracking_stack; depends on nothing.
package mts_pkg;

    localparam int DEFAULT_DEPTH       = 1024;
    localparam int DEFAULT_VALUE_WIDTH = 32;
    localparam int FIELD_WIDTH         = 32;

    // Operation codes carried on the input side.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Result status codes.
    typedef logic [1:0] t_status;
    localparam t_status STAT_OK        = 2'd0;
    localparam t_status STAT_UNDERFLOW = 2'd1;
    localparam t_status STAT_OVERFLOW  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // latch the input item and start the memory reads
        logic commit;  // apply the operation and load the result register
    } t_cmd;

endpackage

### sv/mts_ctrl.sv
// Controller of the max-tracking stack: sequencer state machine and
// output valid flag. Depends on mts_pkg.
module mts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output mts_pkg::t_cmd o_cmd
);

    mts_pkg::t_state r_state;
    mts_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mts_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_s_tready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            mts_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = mts_pkg::ST_FINISH;
                end
            end
            mts_pkg::ST_FINISH: begin
                // The result register must be free or draining this cycle.
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = mts_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mts_pkg::ST_IDLE;
            end
        endcase
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

### sv/mts_dp.sv
// Datapath of the max-tracking stack: data and max memories, counts,
// cached top entries and the result register. Depends on mts_pkg.
module mts_dp #(
    parameter int DEPTH       = mts_pkg::DEFAULT_DEPTH,
    parameter int VALUE_WIDTH = mts_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mts_pkg::t_cmd                   i_cmd,
    input  logic                            i_operation,
    input  logic [mts_pkg::FIELD_WIDTH-1:0] i_push_value,
    output logic [mts_pkg::FIELD_WIDTH-1:0] o_popped_value,
    output logic [mts_pkg::FIELD_WIDTH-1:0] o_top_value,
    output logic [mts_pkg::FIELD_WIDTH-1:0] o_max_value,
    output logic                            o_is_empty,
    output mts_pkg::t_status                o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int FW = mts_pkg::FIELD_WIDTH;
    localparam int EW = (VALUE_WIDTH > FW) ? VALUE_WIDTH : FW;

    logic [VALUE_WIDTH-1:0] data_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] max_mem  [DEPTH];

    logic                   r_op;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [VALUE_WIDTH-1:0] r_rd_data;
    logic [VALUE_WIDTH-1:0] r_rd_max;
    logic [CW-1:0]          r_data_cnt;
    logic [CW-1:0]          n_data_cnt;
    logic [CW-1:0]          r_max_cnt;
    logic [CW-1:0]          n_max_cnt;
    logic [VALUE_WIDTH-1:0] r_top;
    logic [VALUE_WIDTH-1:0] n_top;
    logic [VALUE_WIDTH-1:0] r_max;
    logic [VALUE_WIDTH-1:0] n_max;

    logic [FW-1:0]          r_popped_value;
    logic [FW-1:0]          r_top_value;
    logic [FW-1:0]          r_max_value;
    logic                   r_is_empty;
    mts_pkg::t_status       r_status;

    logic [EW-1:0]          w_in_ext;
    logic [CW-1:0]          w_data_below;
    logic [CW-1:0]          w_max_below;
    logic                   w_data_we;
    logic                   w_max_we;
    logic [VALUE_WIDTH-1:0] w_popped;
    logic [VALUE_WIDTH-1:0] w_top_out;
    logic [VALUE_WIDTH-1:0] w_max_out;
    logic [EW-1:0]          w_popped_ext;
    logic [EW-1:0]          w_top_ext;
    logic [EW-1:0]          w_max_ext;
    mts_pkg::t_status       w_status;

    // Sign-extend the 32-bit field, then hold it at the storage width.
    assign w_in_ext = EW'($signed(i_push_value));

    // Entries just below the current tops; they become the tops on a pop.
    assign w_data_below = r_data_cnt - CW'(2);
    assign w_max_below  = r_max_cnt - CW'(2);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_operation;
            r_val     <= w_in_ext[VALUE_WIDTH-1:0];
            r_rd_data <= data_mem[w_data_below[AW-1:0]];
            r_rd_max  <= max_mem[w_max_below[AW-1:0]];
        end
        if (i_cmd.commit && w_data_we) begin
            data_mem[r_data_cnt[AW-1:0]] <= r_val;
        end
        if (i_cmd.commit && w_max_we) begin
            max_mem[r_max_cnt[AW-1:0]] <= r_val;
        end
    end

    always_comb begin
        n_data_cnt = r_data_cnt;
        n_max_cnt  = r_max_cnt;
        n_top      = r_top;
        n_max      = r_max;
        w_data_we  = 1'b0;
        w_max_we   = 1'b0;
        w_popped   = '0;
        w_status   = mts_pkg::STAT_OK;
        if (r_op == mts_pkg::OP_PUSH) begin
            if (r_data_cnt == CW'(DEPTH)) begin
                w_status = mts_pkg::STAT_OVERFLOW;
            end else begin
                w_data_we  = 1'b1;
                n_data_cnt = r_data_cnt + CW'(1);
                n_top      = r_val;
                if ((r_max_cnt == '0) || ($signed(r_val) >= $signed(r_max))) begin
                    if (r_max_cnt != CW'(DEPTH)) begin
                        w_max_we  = 1'b1;
                        n_max_cnt = r_max_cnt + CW'(1);
                        n_max     = r_val;
                    end
                end
            end
        end else begin
            if (r_data_cnt == '0) begin
                w_status = mts_pkg::STAT_UNDERFLOW;
            end else begin
                w_popped   = r_top;
                n_data_cnt = r_data_cnt - CW'(1);
                n_top      = r_rd_data;
                if ((r_max_cnt != '0) && (r_max == r_top)) begin
                    n_max_cnt = r_max_cnt - CW'(1);
                    n_max     = r_rd_max;
                end
            end
        end
        w_top_out = (n_data_cnt != '0) ? n_top : '0;
        w_max_out = ((n_data_cnt != '0) && (n_max_cnt != '0)) ? n_max : '0;
    end

    // Stored words leave as their raw bits, zero-filled or cut to the field.
    assign w_popped_ext = EW'(w_popped);
    assign w_top_ext    = EW'(w_top_out);
    assign w_max_ext    = EW'(w_max_out);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_cnt <= '0;
            r_max_cnt  <= '0;
        end else if (i_cmd.commit) begin
            r_data_cnt <= n_data_cnt;
            r_max_cnt  <= n_max_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_top          <= n_top;
            r_max          <= n_max;
            r_popped_value <= w_popped_ext[FW-1:0];
            r_top_value    <= w_top_ext[FW-1:0];
            r_max_value    <= w_max_ext[FW-1:0];
            r_is_empty     <= (n_data_cnt == '0);
            r_status       <= w_status;
        end
    end

    assign o_popped_value = r_popped_value;
    assign o_top_value    = r_top_value;
    assign o_max_value    = r_max_value;
    assign o_is_empty     = r_is_empty;
    assign o_status       = r_status;

endmodule

### sv/max_tracking_stack.sv
// Max-tracking stack: LIFO of signed words that also reports its maximum.
// An item is latched in the cycle it is taken; the FINISH state then registers
// its result, waiting while the result register is still occupied. No new item
// is taken until the last commits, a pace set by the synchronous read of the
// entry below the top in the data and max memories. Reset (synchronous,
// active low) empties both stacks at once; memory contents are not cleared.
module max_tracking_stack #(
    parameter int DEPTH       = mts_pkg::DEFAULT_DEPTH,
    parameter int VALUE_WIDTH = mts_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] push_value
    input  logic [0:0]  i_s_tuser,   // [0] operation (0 push, 1 pop)
    // Result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [95:0] o_m_tdata,   // [31:0] popped_value, [63:32] top_value,
                                     // [95:64] max_value
    output logic [2:0]  o_m_tuser    // [0] is_empty, [2:1] status
);

    // The controller sequences each item through two steps: the accepting
    // cycle latches the item and reads the entries just below both tops,
    // and the FINISH step then applies the push or pop and loads the result
    // register. The result register parts the two sides, so a new item is
    // taken while an earlier result still waits for its transfer; an item
    // stalls in its second step only if that register is still occupied.
    mts_pkg::t_cmd    w_cmd;
    mts_pkg::t_status w_status;
    logic             w_is_empty;

    mts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    // The datapath caches the top data entry and the top max entry in
    // registers, so a pop returns its value at once and only needs the
    // memories for the entries that become the new tops.
    mts_dp #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_operation    (i_s_tuser[0]),
        .i_push_value   (i_s_tdata),
        .o_popped_value (o_m_tdata[31:0]),
        .o_top_value    (o_m_tdata[63:32]),
        .o_max_value    (o_m_tdata[95:64]),
        .o_is_empty     (w_is_empty),
        .o_status       (w_status)
    );

    assign o_m_tuser = {w_status, w_is_empty};

    // Only one item is in work at a time.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while an item was in work");

    // A committed result is presented in the following cycle.
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_m_tvalid)
        else $error("committed result not presented");

    // An underflow only happens on an empty stack, which stays empty.
    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (w_status == mts_pkg::STAT_UNDERFLOW)) |-> w_is_empty)
        else $error("underflow reported on a non-empty stack");

    // An overflow only happens on a full stack, so the stack is not empty.
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (w_status == mts_pkg::STAT_OVERFLOW)) |-> !w_is_empty)
        else $error("overflow reported on an empty stack");

endmodule
